### design/rmcr_pkg.sv
// ----------------------------------------------------------------------------
// rmcr_pkg
// Shared types and constants of the roll mode capture ring: item layouts,
// opcodes, configuration register indexes, control states and fixed widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmcr_pkg;

  localparam int DEF_CHANNEL_DEPTH = 8192;
  localparam int DEF_MAX_FILL      = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int SIZE_W     = 14;
  localparam int TPP_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int TIME_MS_W  = 32;
  localparam int NOW_W      = 42;
  localparam int TIME_W     = 48;
  localparam int ADDED_W    = 7;

  localparam logic [SIZE_W-1:0]  RST_CHANNEL_SIZE = SIZE_W'(8192);
  localparam logic [TPP_W-1:0]   RST_TPP_US       = TPP_W'(5);
  localparam logic [BYTE_W-1:0]  RST_EMPTY_MARKER = '0;
  localparam logic [NOW_W-1:0]   US_PER_MS        = NOW_W'(1000);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_TPP   = 2'd2,
    REG_EMPTY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RDWAIT,
    ST_WLO,
    ST_WHI,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [TIME_MS_W-1:0]  time_ms;
    logic [SAMPLE_W-1:0]   sample_a;
    logic [SAMPLE_W-1:0]   sample_b;
    logic                  channel_sel;
    logic [SIZE_W-1:0]     offset_from_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic [ADDED_W-1:0] points_added;
    logic               fill_capped;
  } out_item_t;

  typedef struct packed {
    logic               peak_detect_enable;
    logic [SIZE_W-1:0]  channel_size;
    logic [TPP_W-1:0]   time_per_point_us;
    logic [BYTE_W-1:0]  empty_marker;
  } cfg_t;

endpackage

`default_nettype wire

### design/rmcr_ram.sv
// ----------------------------------------------------------------------------
// rmcr_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/rmcr_cfg.sv
// ----------------------------------------------------------------------------
// rmcr_cfg
// Configuration register file: decode the write index and hold the settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmcr_cfg
  import rmcr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_PEAK:  cfg_nxt.peak_detect_enable = cfg_wdata[0];
        REG_SIZE:  cfg_nxt.channel_size       = cfg_wdata[SIZE_W-1:0];
        REG_TPP:   cfg_nxt.time_per_point_us  = cfg_wdata[TPP_W-1:0];
        REG_EMPTY: cfg_nxt.empty_marker       = cfg_wdata[BYTE_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_detect_enable <= 1'b0;
      cfg_r.channel_size       <= RST_CHANNEL_SIZE;
      cfg_r.time_per_point_us  <= RST_TPP_US;
      cfg_r.empty_marker       <= RST_EMPTY_MARKER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/rmcr_ctrl.sv
// ----------------------------------------------------------------------------
// rmcr_ctrl
// Item sequencer: decode opcodes, drive the sample RAM, run the repeat-fill
// loop, track the write pointer and high-water mark, hold the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmcr_ctrl
  import rmcr_pkg::*;
#(
  parameter int CHANNEL_DEPTH = DEF_CHANNEL_DEPTH,
  parameter int MAX_FILL      = DEF_MAX_FILL
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cfg_t                             cfg,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire in_item_t                         in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output out_item_t                             out_item,
  output logic                                  ram_we,
  output logic [$clog2(CHANNEL_DEPTH)-1:0]      ram_waddr,
  output logic [2*BYTE_W-1:0]                   ram_wdata,
  output logic                                  ram_re,
  output logic [$clog2(CHANNEL_DEPTH)-1:0]      ram_raddr,
  input  wire logic [2*BYTE_W-1:0]              ram_rdata
);

  localparam int PW = $clog2(CHANNEL_DEPTH);
  localparam int SW = $clog2(CHANNEL_DEPTH + 1);
  localparam int MW = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int AW = $clog2(MAX_FILL + 1);

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [NOW_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] nt_r, nt_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [SW-1:0]    hw_r, hw_nxt;
  logic [AW-1:0]    added_r, added_nxt;
  logic             capped_r, capped_nxt;
  logic             rd_empty_r, rd_empty_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic [BYTE_W-1:0] rd_byte_r, rd_byte_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [SW-1:0]    size_c;
  logic [PW-1:0]    pnorm_c;
  logic [SW-1:0]    inc_c;
  logic [PW-1:0]    ptr_inc_c;
  logic [MW:0]      idx_wide_c;
  logic [PW-1:0]    idx_c;
  logic             off_big_c;
  logic [NOW_W-1:0] now_c;
  logic [TIME_W:0]  sum_c;
  logic [TIME_W-1:0] nt_add_c;
  logic             due_c;

  always_comb begin
    if (cfg.channel_size == '0) begin
      size_c = SW'(1);
    end else if (MW'(cfg.channel_size) > MW'(CHANNEL_DEPTH)) begin
      size_c = SW'(CHANNEL_DEPTH);
    end else begin
      size_c = SW'(cfg.channel_size);
    end
  end

  assign pnorm_c   = (SW'(ptr_r) >= size_c) ? '0 : ptr_r;
  assign inc_c     = SW'(ptr_r) + SW'(1);
  assign ptr_inc_c = (inc_c >= size_c) ? '0 : inc_c[PW-1:0];

  assign off_big_c = MW'(item_r.offset_from_end) > MW'(size_c);

  always_comb begin
    if (MW'(pnorm_c) >= MW'(item_r.offset_from_end)) begin
      idx_wide_c = (MW + 1)'(pnorm_c) - (MW + 1)'(item_r.offset_from_end);
    end else begin
      idx_wide_c = (MW + 1)'(pnorm_c) + (MW + 1)'(size_c)
                 - (MW + 1)'(item_r.offset_from_end);
    end
  end
  assign idx_c = idx_wide_c[PW-1:0];

  assign now_c    = NOW_W'(item_r.time_ms) * US_PER_MS;
  assign sum_c    = {1'b0, nt_r} + (TIME_W + 1)'(cfg.time_per_point_us);
  assign nt_add_c = sum_c[TIME_W] ? '1 : sum_c[TIME_W-1:0];
  assign due_c    = nt_r < TIME_W'(now_r);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    now_nxt       = now_r;
    nt_nxt        = nt_r;
    ptr_nxt       = ptr_r;
    hw_nxt        = hw_r;
    added_nxt     = added_r;
    capped_nxt    = capped_r;
    rd_empty_nxt  = rd_empty_r;
    rd_hit_nxt    = rd_hit_r;
    rd_byte_nxt   = rd_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = {item_r.sample_b[BYTE_W-1:0], item_r.sample_a[BYTE_W-1:0]};
    ram_re        = 1'b0;
    ram_raddr     = idx_c;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        added_nxt   = '0;
        capped_nxt  = 1'b0;
        rd_byte_nxt = '0;
        case (item_r.opcode)
          OP_START: begin
            ptr_nxt   = '0;
            nt_nxt    = TIME_W'(now_c);
            state_nxt = ST_DONE;
          end
          OP_ADD: begin
            now_nxt   = now_c;
            ptr_nxt   = pnorm_c;
            state_nxt = cfg.peak_detect_enable ? ST_WLO : ST_WHI;
          end
          OP_READ: begin
            ram_re       = !off_big_c;
            rd_empty_nxt = off_big_c;
            rd_hit_nxt   = SW'(idx_c) < hw_r;
            state_nxt    = ST_RDWAIT;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_RDWAIT: begin
        if (rd_empty_r) begin
          rd_byte_nxt = cfg.empty_marker;
        end else if (!rd_hit_r) begin
          rd_byte_nxt = '0;
        end else if (item_r.channel_sel) begin
          rd_byte_nxt = ram_rdata[2*BYTE_W-1:BYTE_W];
        end else begin
          rd_byte_nxt = ram_rdata[BYTE_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_WLO: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_inc_c;
        if (SW'(ptr_r) == hw_r) begin
          hw_nxt = inc_c;
        end
        state_nxt = ST_WHI;
      end
      ST_WHI: begin
        ram_we    = 1'b1;
        ram_wdata = {item_r.sample_b[2*BYTE_W-1:BYTE_W],
                     item_r.sample_a[2*BYTE_W-1:BYTE_W]};
        ptr_nxt   = ptr_inc_c;
        if (SW'(ptr_r) == hw_r) begin
          hw_nxt = inc_c;
        end
        added_nxt = added_r + AW'(1);
        nt_nxt    = nt_add_c;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!due_c) begin
          state_nxt = ST_DONE;
        end else if (added_r >= AW'(MAX_FILL)) begin
          capped_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = cfg.peak_detect_enable ? ST_WLO : ST_WHI;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.read_byte    = rd_byte_r;
          out_item_nxt.points_added = ADDED_W'(added_r);
          out_item_nxt.fill_capped  = capped_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nt_r        <= '0;
      ptr_r       <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nt_r        <= nt_nxt;
      ptr_r       <= ptr_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    now_r      <= now_nxt;
    added_r    <= added_nxt;
    capped_r   <= capped_nxt;
    rd_empty_r <= rd_empty_nxt;
    rd_hit_r   <= rd_hit_nxt;
    rd_byte_r  <= rd_byte_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WLO || state_r == ST_WHI) |-> (SW'(ptr_r) < size_c))
    else $error("write pointer outside ring");

  a_ptr_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (SW'(ptr_r) <= hw_r))
    else $error("write beyond high-water mark");

  a_hw_depth: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= SW'(CHANNEL_DEPTH))
    else $error("high-water mark beyond depth");

  a_cap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.fill_capped)
      |-> (out_item_r.points_added == ADDED_W'(MAX_FILL)))
    else $error("capped item without full repeat count");

  a_start_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP && item_r.opcode == OP_START) |=> (ptr_r == '0))
    else $error("start did not rewind pointer");

endmodule

`default_nettype wire

### design/roll_mode_capture_ring.sv
// ----------------------------------------------------------------------------
// roll_mode_capture_ring
// Two-channel circular capture store for oscilloscope roll mode.
//
// Input items carry an opcode: start (rewind, record start time), add point
// (write the sample bytes of both channels at the shared pointer, then
// repeat the point while it is still behind the given time, up to MAX_FILL
// points) and read from end (return one channel's byte a given distance
// behind the pointer). Every item gives exactly one result item.
// Both channels share one RAM entry per byte position, 16 bits wide.
// Each point of an add point item writes one byte pair per step, the low
// pair and then the high pair with peak detect, the high pair alone
// without, and then checks the point time.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. While out_stall is high the result
// holds and a further item finishes work and then waits behind it.
// Reset clears pointer, time and the high-water mark of written entries;
// unwritten entries read as zero, so no clearing sweep is needed.
// Configuration writes (cfg_we/cfg_idx/cfg_wdata) belong between items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module roll_mode_capture_ring
  import rmcr_pkg::*;
#(
  parameter int CHANNEL_DEPTH = DEF_CHANNEL_DEPTH,
  parameter int MAX_FILL      = DEF_MAX_FILL
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item
);

  localparam int PW = $clog2(CHANNEL_DEPTH);

  cfg_t              cfg;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [2*BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [2*BYTE_W-1:0] ram_rdata;

  rmcr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rmcr_ram #(
    .WIDTH (2 * BYTE_W),
    .DEPTH (CHANNEL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmcr_ctrl #(
    .CHANNEL_DEPTH (CHANNEL_DEPTH),
    .MAX_FILL      (MAX_FILL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the roll mode capture ring. A behavioral copy of
// both channel rings, the shared pointer and the point timer predicts one
// result per accepted item; a monitor compares each result field by field
// with the oldest prediction. Directed tests cover reset defaults, odd ring
// sizes, size limits and a stale pointer; random phases then run frames of
// add point, read, start and random items under random idling on both ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rmcr_pkg::*;

  localparam int unsigned DEPTH = DEF_CHANNEL_DEPTH;
  localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  bit idle_on = 1'b1;
  int unsigned mismatches = 0;

  // ring mirror
  bit [7:0] ring_a [DEPTH];
  bit [7:0] ring_b [DEPTH];
  int unsigned ring_ptr = 0;
  logic [31:0] point_total = '0;
  logic [TIME_W-1:0] next_point_us = '0;

  // register mirror
  bit cfg_peak = 1'b0;
  logic [SIZE_W-1:0] cfg_size = RST_CHANNEL_SIZE;
  logic [TPP_W-1:0] cfg_tpp = RST_TPP_US;
  logic [BYTE_W-1:0] cfg_empty = RST_EMPTY_MARKER;

  out_item_t pending_results [$];
  out_item_t want;

  roll_mode_capture_ring dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  function automatic int unsigned ring_len();
    if (cfg_size == 0) return 1;
    if (cfg_size > DEPTH) return DEPTH;
    return cfg_size;
  endfunction

  function automatic void ring_put(logic [7:0] va, logic [7:0] vb, int unsigned len);
    if (ring_ptr >= len) ring_ptr = 0;
    ring_a[ring_ptr] = va;
    ring_b[ring_ptr] = vb;
    ring_ptr++;
    if (ring_ptr >= len) ring_ptr = 0;
  endfunction

  function automatic out_item_t ring_predict(in_item_t it);
    out_item_t r;
    logic [NOW_W-1:0] now_us;
    logic [TIME_W:0] sum;
    int unsigned len, p, idx, off;
    bit done;
    r = '0;
    now_us = NOW_W'(it.time_ms) * US_PER_MS;
    len = ring_len();
    off = it.offset_from_end;
    case (it.opcode)
      OP_START: begin
        point_total = '0;
        ring_ptr = 0;
        next_point_us = TIME_W'(now_us);
      end
      OP_ADD: begin
        done = 1'b0;
        while (!done) begin
          if (cfg_peak) ring_put(it.sample_a[7:0], it.sample_b[7:0], len);
          ring_put(it.sample_a[15:8], it.sample_b[15:8], len);
          point_total++;
          r.points_added++;
          sum = {1'b0, next_point_us} + (TIME_W + 1)'(cfg_tpp);
          next_point_us = (sum > {1'b0, TIME_SAT}) ? TIME_SAT : sum[TIME_W-1:0];
          if (!(next_point_us < TIME_W'(now_us))) begin
            done = 1'b1;
          end else if (r.points_added >= DEF_MAX_FILL) begin
            r.fill_capped = 1'b1;
            done = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (off > len) begin
          r.read_byte = cfg_empty;
        end else begin
          p = (ring_ptr >= len) ? 0 : ring_ptr;
          idx = (p >= off) ? p - off : p + len - off;
          if (idx >= len) idx = 0;
          r.read_byte = it.channel_sel ? ring_b[idx] : ring_a[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t pack_item(opcode_t op, logic [31:0] t, logic [15:0] sa,
                                         logic [15:0] sb, logic sel, logic [13:0] off);
    in_item_t it;
    it.opcode = op;
    it.time_ms = t;
    it.sample_a = sa;
    it.sample_b = sb;
    it.channel_sel = sel;
    it.offset_from_end = off;
    return it;
  endfunction

  always @(posedge clk) out_stall <= idle_on && ($urandom_range(99) < 15);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result byte=%h added=%0d capped=%b", $realtime,
                   out_item.read_byte, out_item.points_added, out_item.fill_capped);
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_byte !== want.read_byte ||
            out_item.points_added !== want.points_added ||
            out_item.fill_capped !== want.fill_capped) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp byte=%h added=%0d capped=%b",
                      " got byte=%h added=%0d capped=%b"},
                     $realtime, want.read_byte, want.points_added, want.fill_capped,
                     out_item.read_byte, out_item.points_added, out_item.fill_capped);
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(ring_predict(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_we high; apply_cfg lowers it
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PEAK:  cfg_peak = data[0];
      REG_SIZE:  cfg_size = data[SIZE_W-1:0];
      REG_TPP:   cfg_tpp = data[TPP_W-1:0];
      REG_EMPTY: cfg_empty = data[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input bit peak, input logic [SIZE_W-1:0] len,
                           input logic [TPP_W-1:0] tpp, input logic [BYTE_W-1:0] empty);
    cfg_write(REG_PEAK, CFG_DATA_W'(peak));
    cfg_write(REG_SIZE, CFG_DATA_W'(len));
    cfg_write(REG_TPP, CFG_DATA_W'(tpp));
    cfg_write(REG_EMPTY, CFG_DATA_W'(empty));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'h0, 16'hFFFF, 16'h0000, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'h1, 16'h1234, 16'hABCD, 1'b1, 14'd0));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b1, 14'd1));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd8192));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd8193));
    send_item(pack_item(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 14'h3FFF));
    wait_idle();
  endtask

  task automatic test_odd_ring();
    apply_cfg(1'b1, 14'd7, 20'd0, 8'hA5);
    send_item(pack_item(OP_START, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'hFFFF_FFFF, 16'h00FF, 16'hFF00, 1'b0, 14'd0));
    send_item(pack_item(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 14'h3FFF));
    send_item(pack_item(OP_START, 32'h0, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'h1, 16'h5A3C, 16'hC35A, 1'b0, 14'd0));
    for (int off = 0; off <= 8; off += 2) begin
      send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, off[0], 14'(off)));
      send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, ~off[0], 14'(off + 1)));
    end
    wait_idle();
  endtask

  task automatic test_size_limits();
    apply_cfg(1'b0, 14'd0, 20'hFFFFF, 8'h00);
    send_item(pack_item(OP_START, 32'h0, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'd5, 16'h8001, 16'h7FFE, 1'b0, 14'd0));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b1, 14'd1));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd2));
    wait_idle();
    apply_cfg(1'b1, 14'h3FFF, 20'd1000, 8'h3C);
    send_item(pack_item(OP_START, 32'h0, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'd3, 16'h1122, 16'h3344, 1'b0, 14'd0));
    wait_idle();
    // shrink below the pointer
    apply_cfg(1'b1, 14'd3, 20'd1000, 8'h3C);
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd0));
    send_item(pack_item(OP_ADD, 32'd3, 16'h5566, 16'h7788, 1'b0, 14'd0));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b1, 14'd2));
    send_item(pack_item(OP_READ, 32'h0, 16'h0, 16'h0, 1'b0, 14'd4));
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned now_ms, len, pick, off;
    logic [SIZE_W-1:0] size_w;
    logic [TPP_W-1:0] tpp;
    in_item_t it;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: size_w = 14'd1;
        1: size_w = 14'h3FFF;
        2: size_w = 14'd0;
        7: size_w = 14'd8192;
        default: size_w = ($urandom_range(3) == 0) ? 14'($urandom_range(8192, 1))
                                                    : 14'($urandom_range(40, 2));
      endcase
      case ($urandom_range(5))
        0: tpp = 20'd0;
        1: tpp = 20'd5;
        2: tpp = 20'd500;
        3: tpp = 20'd1000;
        4: tpp = 20'hFFFFF;
        default: tpp = 20'($urandom_range(3000, 100));
      endcase
      apply_cfg(ph[0], size_w, tpp, 8'($urandom));
      idle_on = (ph != 3);
      len = ring_len();
      now_ms = $urandom;
      send_item(pack_item(OP_START, now_ms, 16'($urandom), 16'($urandom),
                          1'($urandom), 14'($urandom)));
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          now_ms += $urandom_range(3);
          send_item(pack_item(OP_ADD, now_ms, 16'($urandom), 16'($urandom),
                              1'($urandom), 14'($urandom)));
        end else if (pick < 80) begin
          case ($urandom_range(9))
            7: off = len;
            8: off = $urandom_range(16383);
            9: off = 0;
            default: off = $urandom_range(len + 1);
          endcase
          send_item(pack_item(OP_READ, $urandom, 16'($urandom), 16'($urandom),
                              1'($urandom), 14'(off)));
        end else if (pick < 88) begin
          now_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFE : $urandom;
          send_item(pack_item(OP_START, now_ms, 16'($urandom), 16'($urandom),
                              1'($urandom), 14'($urandom)));
        end else begin
          it = in_item_t'(81'({$urandom, $urandom, $urandom}));
          send_item(it);
        end
      end
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_odd_ring();
    test_size_limits();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
